@@ design/qtr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package qtr_pkg;

  localparam int POS_W = 12;
  localparam int SCALE_W = 24;
  localparam int OP_W = 2;
  localparam int ROW_W = 2;
  localparam int Q_W = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int CORDIC_STEPS = 24;
  localparam int CNT_W = 6;
  localparam int CW = 34;
  localparam int ACC_W = 40;
  localparam int PROD_W = 2 * CW;

  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_MOTION = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP = 2'd2;
  localparam logic [OP_W-1:0] OP_RESET = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_X_SCALE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_Y_SCALE = 2'd1;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd16384;

  localparam logic signed [Q_W-1:0] ONE_Q30 = 32'sd1073741824;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [ACC_W-1:0] DXY_LIMIT = 40'sd2147483647;
  localparam logic signed [ACC_W-1:0] SAT_MAX = 40'sd2147483647;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -40'sd2147483648;

  typedef enum logic [4:0] {
    DP_NOP, DP_LATCH, DP_MUL_DX, DP_SET_DX, DP_MUL_DY, DP_SET_DY,
    DP_MUL_DXX, DP_SET_RAD, DP_MUL_DYY, DP_ADD_RAD, DP_SQRT,
    DP_COPY_CQ, DP_CORDIC_INIT, DP_CORDIC, DP_QUAD, DP_MUL_NY, DP_MUL_NX,
    DP_DIV_INIT, DP_DIV, DP_DIV_END_Y, DP_DIV_END_X, DP_MAC_CLR,
    DP_QMUL, DP_QACC, DP_QSTORE, DP_MAT_INIT, DP_MMUL, DP_MACC,
    DP_MSTORE, DP_COMMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic [CNT_W-1:0] cnt;
  } ctl_cmd_t;

  typedef struct packed {
    logic dragging;
    logic a_zero;
  } dp_status_t;

  typedef struct packed {
    logic [1:0] a;
    logic [1:0] b;
    logic neg;
  } mterm_t;

  // arctangent of 2^-i in 2^32-per-turn units
  function automatic logic [30:0] atan_turn(input logic [4:0] i);
    logic [30:0] v;
    begin
      unique case (i)
        5'd0: v = 31'd536870912;  5'd1: v = 31'd316933406;
        5'd2: v = 31'd167458907;  5'd3: v = 31'd85004756;
        5'd4: v = 31'd42667331;   5'd5: v = 31'd21354465;
        5'd6: v = 31'd10680350;   5'd7: v = 31'd5340245;
        5'd8: v = 31'd2670163;    5'd9: v = 31'd1335087;
        5'd10: v = 31'd667544;    5'd11: v = 31'd333772;
        5'd12: v = 31'd166886;    5'd13: v = 31'd83443;
        5'd14: v = 31'd41722;     5'd15: v = 31'd20861;
        5'd16: v = 31'd10430;     5'd17: v = 31'd5215;
        5'd18: v = 31'd2608;      5'd19: v = 31'd1304;
        5'd20: v = 31'd652;       5'd21: v = 31'd326;
        5'd22: v = 31'd163;       5'd23: v = 31'd81;
        5'd24: v = 31'd41;        5'd25: v = 31'd20;
        5'd26: v = 31'd10;        5'd27: v = 31'd5;
        5'd28: v = 31'd3;         5'd29: v = 31'd1;
        default: v = 31'd0;
      endcase
      return v;
    end
  endfunction

  function automatic logic signed [Q_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    begin
      if (v > SAT_MAX) return SAT_MAX[Q_W-1:0];
      if (v < SAT_MIN) return SAT_MIN[Q_W-1:0];
      return v[Q_W-1:0];
    end
  endfunction

  function automatic logic signed [Q_W-1:0] clamp_dxy(input logic signed [ACC_W-1:0] v);
    begin
      if (v > DXY_LIMIT) return DXY_LIMIT[Q_W-1:0];
      if (v < -DXY_LIMIT) return 32'(-DXY_LIMIT);
      return v[Q_W-1:0];
    end
  endfunction

  // sign of term j in component i of the product dq * cq
  function automatic logic quat_neg(input logic [1:0] i, input logic [1:0] j);
    begin
      return (i == 2'd0 && j != 2'd0) || (i == 2'd1 && j == 2'd3) ||
             (i == 2'd2 && j == 2'd1) || (i == 2'd3 && j == 2'd2);
    end
  endfunction

  // operands (w=0, x=1, y=2, z=3) of term t of matrix entry e
  function automatic mterm_t mat_term(input logic [3:0] e, input logic t);
    mterm_t m;
    begin
      unique case ({e, t})
        5'd0:  m = '{2'd2, 2'd2, 1'b1};
        5'd1:  m = '{2'd3, 2'd3, 1'b1};
        5'd2:  m = '{2'd1, 2'd2, 1'b0};
        5'd3:  m = '{2'd3, 2'd0, 1'b0};
        5'd4:  m = '{2'd3, 2'd1, 1'b0};
        5'd5:  m = '{2'd2, 2'd0, 1'b1};
        5'd6:  m = '{2'd1, 2'd2, 1'b0};
        5'd7:  m = '{2'd3, 2'd0, 1'b1};
        5'd8:  m = '{2'd3, 2'd3, 1'b1};
        5'd9:  m = '{2'd1, 2'd1, 1'b1};
        5'd10: m = '{2'd2, 2'd3, 1'b0};
        5'd11: m = '{2'd1, 2'd0, 1'b0};
        5'd12: m = '{2'd3, 2'd1, 1'b0};
        5'd13: m = '{2'd2, 2'd0, 1'b0};
        5'd14: m = '{2'd2, 2'd3, 1'b0};
        5'd15: m = '{2'd1, 2'd0, 1'b1};
        5'd16: m = '{2'd1, 2'd1, 1'b1};
        5'd17: m = '{2'd2, 2'd2, 1'b1};
        default: m = '{2'd0, 2'd0, 1'b0};
      endcase
      return m;
    end
  endfunction

  function automatic logic mat_diag(input logic [3:0] e);
    begin
      return e == 4'd0 || e == 4'd4 || e == 4'd8;
    end
  endfunction

endpackage
`default_nettype wire

@@ design/qtr_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface qtr_item_if import qtr_pkg::*; ();
  logic valid;
  logic ready;
  logic [OP_W-1:0] operation;
  logic [POS_W-1:0] x_pos;
  logic [POS_W-1:0] y_pos;
  modport source(output valid, output operation, output x_pos, output y_pos, input ready);
  modport sink(input valid, input operation, input x_pos, input y_pos, output ready);
endinterface

interface qtr_row_if import qtr_pkg::*; ();
  logic valid;
  logic ready;
  logic [ROW_W-1:0] row_index;
  logic signed [Q_W-1:0] col_zero;
  logic signed [Q_W-1:0] col_one;
  logic signed [Q_W-1:0] col_two;
  logic last_row;
  modport source(output valid, output row_index, output col_zero, output col_one,
                 output col_two, output last_row, input ready);
  modport sink(input valid, input row_index, input col_zero, input col_one,
               input col_two, input last_row, output ready);
endinterface
`default_nettype wire

@@ design/qtr_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module qtr_ctrl import qtr_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic [OP_W-1:0] in_op,
  output      logic            in_ready,
  input  wire dp_status_t      status,
  input  wire logic            out_busy,
  output      logic            out_load,
  output      ctl_cmd_t        cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_MUL_DX, S_SET_DX, S_MUL_DY, S_SET_DY, S_MUL_DXX, S_SET_RAD,
    S_MUL_DYY, S_ADD_RAD, S_SQRT, S_CHECK, S_CORDIC, S_QUAD, S_MUL_N,
    S_DIV_INIT, S_DIV, S_DIV_END, S_QCLR, S_QMUL, S_QACC, S_QSTORE,
    S_MINIT, S_MMUL, S_MACC, S_MSTORE, S_COMMIT, S_EMIT
  } state_t;

  state_t state;
  logic [CNT_W-1:0] cnt;
  logic div_x;
  logic is_stop;

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_EMIT) && !out_busy;

  always_comb begin
    cmd.cnt = cnt;
    unique case (state)
      S_IDLE:     cmd.op = in_valid ? DP_LATCH : DP_NOP;
      S_MUL_DX:   cmd.op = DP_MUL_DX;
      S_SET_DX:   cmd.op = DP_SET_DX;
      S_MUL_DY:   cmd.op = DP_MUL_DY;
      S_SET_DY:   cmd.op = DP_SET_DY;
      S_MUL_DXX:  cmd.op = DP_MUL_DXX;
      S_SET_RAD:  cmd.op = DP_SET_RAD;
      S_MUL_DYY:  cmd.op = DP_MUL_DYY;
      S_ADD_RAD:  cmd.op = DP_ADD_RAD;
      S_SQRT:     cmd.op = DP_SQRT;
      S_CHECK:    cmd.op = status.a_zero ? DP_COPY_CQ : DP_CORDIC_INIT;
      S_CORDIC:   cmd.op = DP_CORDIC;
      S_QUAD:     cmd.op = DP_QUAD;
      S_MUL_N:    cmd.op = div_x ? DP_MUL_NX : DP_MUL_NY;
      S_DIV_INIT: cmd.op = DP_DIV_INIT;
      S_DIV:      cmd.op = DP_DIV;
      S_DIV_END:  cmd.op = div_x ? DP_DIV_END_X : DP_DIV_END_Y;
      S_QCLR:     cmd.op = DP_MAC_CLR;
      S_QMUL:     cmd.op = DP_QMUL;
      S_QACC:     cmd.op = DP_QACC;
      S_QSTORE:   cmd.op = DP_QSTORE;
      S_MINIT:    cmd.op = DP_MAT_INIT;
      S_MMUL:     cmd.op = DP_MMUL;
      S_MACC:     cmd.op = DP_MACC;
      S_MSTORE:   cmd.op = DP_MSTORE;
      S_COMMIT:   cmd.op = DP_COMMIT;
      S_EMIT:     cmd.op = DP_NOP;
      default:    cmd.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      div_x <= 1'b0;
      is_stop <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            is_stop <= (in_op == OP_STOP);
            unique case (in_op)
              OP_MOTION: state <= status.dragging ? S_MUL_DX : S_EMIT;
              OP_STOP:   state <= status.dragging ? S_MUL_DX : S_COMMIT;
              default:   state <= S_EMIT;
            endcase
          end
        end
        S_MUL_DX:  state <= S_SET_DX;
        S_SET_DX:  state <= S_MUL_DY;
        S_MUL_DY:  state <= S_SET_DY;
        S_SET_DY:  state <= S_MUL_DXX;
        S_MUL_DXX: state <= S_SET_RAD;
        S_SET_RAD: state <= S_MUL_DYY;
        S_MUL_DYY: state <= S_ADD_RAD;
        S_ADD_RAD: begin
          state <= S_SQRT;
          cnt <= '0;
        end
        S_SQRT: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(Q_W - 1)) state <= S_CHECK;
        end
        S_CHECK: begin
          cnt <= '0;
          state <= status.a_zero ? S_MINIT : S_CORDIC;
        end
        S_CORDIC: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(CORDIC_STEPS - 1)) state <= S_QUAD;
        end
        S_QUAD: begin
          div_x <= 1'b0;
          state <= S_MUL_N;
        end
        S_MUL_N: state <= S_DIV_INIT;
        S_DIV_INIT: begin
          cnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (&cnt) state <= S_DIV_END;
        end
        S_DIV_END: begin
          cnt <= '0;
          if (div_x) begin
            state <= S_QCLR;
          end else begin
            div_x <= 1'b1;
            state <= S_MUL_N;
          end
        end
        S_QCLR: state <= S_QMUL;
        S_QMUL: state <= S_QACC;
        S_QACC: begin
          if (cnt[1:0] == 2'd3) begin
            state <= S_QSTORE;
          end else begin
            cnt <= cnt + 1'b1;
            state <= S_QMUL;
          end
        end
        S_QSTORE: begin
          if (cnt[3:2] == 2'd3) begin
            cnt <= '0;
            state <= S_MINIT;
          end else begin
            cnt <= cnt + 1'b1;
            state <= S_QCLR;
          end
        end
        S_MINIT: state <= S_MMUL;
        S_MMUL: state <= S_MACC;
        S_MACC: begin
          if (cnt[0]) begin
            state <= S_MSTORE;
          end else begin
            cnt <= cnt + 1'b1;
            state <= S_MMUL;
          end
        end
        S_MSTORE: begin
          cnt <= cnt + 1'b1;
          if (cnt[4:1] == 4'd8) state <= is_stop ? S_COMMIT : S_EMIT;
          else state <= S_MINIT;
        end
        S_COMMIT: state <= S_EMIT;
        S_EMIT: if (!out_busy) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/qtr_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module qtr_dpath import qtr_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_write,
  input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [SCALE_W-1:0]      cfg_data,
  input  wire logic [OP_W-1:0]         in_op,
  input  wire logic [POS_W-1:0]        in_x,
  input  wire logic [POS_W-1:0]        in_y,
  input  wire ctl_cmd_t                cmd,
  output      dp_status_t              status,
  output      logic signed [Q_W-1:0]   mat [9]
);

  logic [SCALE_W-1:0] x_scale, y_scale;
  logic [POS_W-1:0] anchor_x, anchor_y, xp, yp;
  logic dragging;
  logic signed [Q_W-1:0] dx, dy;
  logic [63:0] rad;
  logic [32:0] sq_rem;
  logic [Q_W-1:0] root;
  logic signed [CW-1:0] cx, cy, sin_v;
  logic signed [Q_W-1:0] cz;
  logic [1:0] quad;
  logic [63:0] dvd;
  logic [Q_W-1:0] drem;
  logic div_neg;
  logic signed [Q_W-1:0] dq [4];
  logic signed [Q_W-1:0] cq [4];
  logic signed [Q_W-1:0] wq [4];
  logic signed [ACC_W-1:0] acc;
  logic signed [PROD_W-1:0] prod;

  logic signed [CW-1:0] mul_a, mul_b;
  logic signed [POS_W:0] off_x, off_y;
  mterm_t mt;
  logic [34:0] rem_t, trial;
  logic [32:0] div_r;
  logic signed [CW-1:0] cxs, cys, c_q, s_q;
  logic signed [PROD_W-1:0] pmag, r30, r29;
  logic signed [ACC_W-1:0] term30, term29;
  logic signed [Q_W-1:0] div_q;

  assign status.dragging = dragging;
  assign status.a_zero = (root == '0);

  assign off_x = $signed({1'b0, xp}) - $signed({1'b0, anchor_x});
  assign off_y = $signed({1'b0, yp}) - $signed({1'b0, anchor_y});
  assign mt = mat_term(cmd.cnt[4:1], cmd.cnt[0]);

  always_comb begin
    unique case (cmd.op)
      DP_MUL_DX: begin
        mul_a = CW'(off_x);
        mul_b = $signed({{(CW - SCALE_W){1'b0}}, x_scale});
      end
      DP_MUL_DY: begin
        mul_a = CW'(off_y);
        mul_b = $signed({{(CW - SCALE_W){1'b0}}, y_scale});
      end
      DP_MUL_DXX: begin
        mul_a = CW'(dx);
        mul_b = CW'(dx);
      end
      DP_MUL_DYY: begin
        mul_a = CW'(dy);
        mul_b = CW'(dy);
      end
      DP_MUL_NY: begin
        mul_a = CW'(dy);
        mul_b = sin_v;
      end
      DP_MUL_NX: begin
        mul_a = CW'(dx);
        mul_b = sin_v;
      end
      DP_QMUL: begin
        mul_a = CW'(dq[cmd.cnt[1:0]]);
        mul_b = CW'(cq[cmd.cnt[3:2] ^ cmd.cnt[1:0]]);
      end
      DP_MMUL: begin
        mul_a = CW'(wq[mt.a]);
        mul_b = CW'(wq[mt.b]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // square root: one result bit per step
  assign rem_t = {sq_rem, rad[63:62]};
  assign trial = {1'b0, root, 2'b01};
  // divider: one quotient bit per step
  assign div_r = {drem, dvd[63]};

  assign cxs = cx >>> cmd.cnt[4:0];
  assign cys = cy >>> cmd.cnt[4:0];

  always_comb begin
    unique case (quad)
      2'd0: begin c_q = cx;  s_q = cy;  end
      2'd1: begin c_q = -cy; s_q = cx;  end
      2'd2: begin c_q = -cx; s_q = -cy; end
      2'd3: begin c_q = cy;  s_q = -cx; end
      default: begin c_q = cx; s_q = cy; end
    endcase
  end

  assign pmag = prod[PROD_W-1] ? -prod : prod;
  assign r30 = (prod + PROD_W'(64'sd536870912)) >>> 30;
  assign r29 = (prod + PROD_W'(64'sd268435456)) >>> 29;
  assign term30 = r30[ACC_W-1:0];
  assign term29 = r29[ACC_W-1:0];

  always_comb begin
    if (div_neg) div_q = (dvd > 64'h8000_0000) ? SAT_MIN[Q_W-1:0] : -dvd[Q_W-1:0];
    else div_q = (dvd > 64'h7FFF_FFFF) ? SAT_MAX[Q_W-1:0] : dvd[Q_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_scale <= SCALE_RESET;
      y_scale <= SCALE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_X_SCALE: x_scale <= cfg_data;
        CFG_Y_SCALE: y_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_x <= '0;
      anchor_y <= '0;
      dragging <= 1'b0;
      root <= '0;
      for (int i = 0; i < 4; i++) begin
        cq[i] <= (i == 0) ? ONE_Q30 : '0;
        wq[i] <= (i == 0) ? ONE_Q30 : '0;
      end
      for (int i = 0; i < 9; i++) mat[i] <= (i % 4 == 0) ? ONE_Q30 : '0;
    end else begin
      unique case (cmd.op)
        DP_LATCH: begin
          xp <= in_x;
          yp <= in_y;
          if (in_op == OP_START) begin
            anchor_x <= in_x;
            anchor_y <= in_y;
            dragging <= 1'b1;
          end
          if (in_op == OP_RESET) begin
            for (int i = 0; i < 4; i++) begin
              cq[i] <= (i == 0) ? ONE_Q30 : '0;
              wq[i] <= (i == 0) ? ONE_Q30 : '0;
            end
            for (int i = 0; i < 9; i++) mat[i] <= (i % 4 == 0) ? ONE_Q30 : '0;
          end
        end
        DP_SET_DX: dx <= clamp_dxy(prod[ACC_W-1:0]);
        DP_SET_DY: dy <= clamp_dxy(prod[ACC_W-1:0]);
        DP_SET_RAD: begin
          rad <= prod[63:0];
          sq_rem <= '0;
          root <= '0;
        end
        DP_ADD_RAD: rad <= rad + prod[63:0];
        DP_SQRT: begin
          rad <= {rad[61:0], 2'b00};
          if (rem_t >= trial) begin
            sq_rem <= 33'(rem_t - trial);
            root <= {root[Q_W-2:0], 1'b1};
          end else begin
            sq_rem <= rem_t[32:0];
            root <= {root[Q_W-2:0], 1'b0};
          end
        end
        DP_COPY_CQ: for (int i = 0; i < 4; i++) wq[i] <= cq[i];
        DP_CORDIC_INIT: begin
          // phase = low 25 bits of a, widened to 32-bit turns
          cx <= CORDIC_GAIN;
          cy <= '0;
          cz <= $signed({2'b00, root[22:0], 7'b0});
          quad <= root[24:23];
        end
        DP_CORDIC: begin
          if (!cz[Q_W-1]) begin
            cx <= cx - cys;
            cy <= cy + cxs;
            cz <= cz - $signed({1'b0, atan_turn(cmd.cnt[4:0])});
          end else begin
            cx <= cx + cys;
            cy <= cy - cxs;
            cz <= cz + $signed({1'b0, atan_turn(cmd.cnt[4:0])});
          end
        end
        DP_QUAD: begin
          dq[0] <= sat32(ACC_W'(c_q));
          dq[3] <= '0;
          sin_v <= s_q;
        end
        DP_DIV_INIT: begin
          div_neg <= prod[PROD_W-1];
          dvd <= pmag[63:0];
          drem <= '0;
        end
        DP_DIV: begin
          if (div_r >= {1'b0, root}) begin
            drem <= Q_W'(div_r - {1'b0, root});
            dvd <= {dvd[62:0], 1'b1};
          end else begin
            drem <= div_r[Q_W-1:0];
            dvd <= {dvd[62:0], 1'b0};
          end
        end
        DP_DIV_END_Y: dq[1] <= div_q;
        DP_DIV_END_X: dq[2] <= div_q;
        DP_MAC_CLR: acc <= '0;
        DP_QACC: begin
          if (quat_neg(cmd.cnt[3:2], cmd.cnt[1:0])) acc <= acc - term30;
          else acc <= acc + term30;
        end
        DP_QSTORE: wq[cmd.cnt[3:2]] <= sat32(acc);
        DP_MAT_INIT: acc <= mat_diag(cmd.cnt[4:1]) ? ACC_W'(ONE_Q30) : '0;
        DP_MACC: begin
          if (mt.neg) acc <= acc - term29;
          else acc <= acc + term29;
        end
        DP_MSTORE: mat[cmd.cnt[4:1]] <= sat32(acc);
        DP_COMMIT: begin
          for (int i = 0; i < 4; i++) cq[i] <= wq[i];
          dragging <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/qtr_outbuf.sv @@
`timescale 1ns / 1ps
`default_nettype none
module qtr_outbuf import qtr_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire logic signed [Q_W-1:0] mat [9],
  output      logic                  busy,
  qtr_row_if.source                  rows
);

  logic signed [Q_W-1:0] snap [9];
  logic [ROW_W-1:0] row;
  logic valid;

  assign busy = valid;
  assign rows.valid = valid;
  assign rows.row_index = row;
  assign rows.last_row = (row == 2'd2);

  always_comb begin
    unique case (row)
      2'd0: begin
        rows.col_zero = snap[0]; rows.col_one = snap[1]; rows.col_two = snap[2];
      end
      2'd1: begin
        rows.col_zero = snap[3]; rows.col_one = snap[4]; rows.col_two = snap[5];
      end
      default: begin
        rows.col_zero = snap[6]; rows.col_one = snap[7]; rows.col_two = snap[8];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) for (int i = 0; i < 9; i++) snap[i] <= mat[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      row <= '0;
    end else if (load) begin
      valid <= 1'b1;
      row <= '0;
    end else if (valid && rows.ready) begin
      row <= row + 1'b1;
      if (row == 2'd2) valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ design/quaternion_trackball_rotation_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Virtual trackball: start/motion/stop/reset pointer items in, three rows of the
// 3x3 rotation matrix (Q2.30) out per item, the third flagged last_row. Start,
// reset, and motion or stop while not dragging skip the arithmetic. A motion
// or stop with a drag in progress is paced by the shared multiplier and the
// bit-serial units: 32 square-root steps, CORDIC_STEPS CORDIC steps, two
// 64-step divisions, then 16 quaternion and 18 matrix multiply-accumulates.
// With a zero offset the CORDIC, divisions and quaternion product are skipped.
// Rows wait in an output buffer so the next item can start while they drain; a
// full buffer holds the controller until it empties. x_scale/y_scale may only
// be written while idle; register indexes beyond 1 are ignored.
module quaternion_trackball_rotation_unit import qtr_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [SCALE_W-1:0]     cfg_data,
  qtr_item_if.sink                    items,
  qtr_row_if.source                   rows
);

  ctl_cmd_t cmd;
  dp_status_t status;
  logic out_busy, out_load;
  logic signed [Q_W-1:0] mat [9];

  qtr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_op    (items.operation),
    .in_ready (items.ready),
    .status   (status),
    .out_busy (out_busy),
    .out_load (out_load),
    .cmd      (cmd)
  );

  qtr_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_op     (items.operation),
    .in_x      (items.x_pos),
    .in_y      (items.y_pos),
    .cmd       (cmd),
    .status    (status),
    .mat       (mat)
  );

  qtr_outbuf u_outbuf (
    .clk  (clk),
    .rst  (rst),
    .load (out_load),
    .mat  (mat),
    .busy (out_busy),
    .rows (rows)
  );

endmodule
`default_nettype wire
